/* design/assert_macros.svh */
// Shared assertion shorthands for the slicer checkers.
// Both expect clk_i in the scope where they are used; ASSERT_CLK also expects rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check at every rising edge while out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/atps_pkg.sv */
package atps_pkg;

  localparam int unsigned WidthW   = 8;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned ClassW   = 2;
  localparam int unsigned OutDataW = 8;

  localparam logic [WidthW-1:0]   CalMinReset  = 8'd255;
  localparam logic [WidthW-1:0]   CalMaxReset  = 8'd0;
  localparam logic [WidthW-1:0]   CalCurReset  = 8'd127;
  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd1953;

  // Class codes
  localparam logic signed [ClassW-1:0] ClsShort = -2'sd1;
  localparam logic signed [ClassW-1:0] ClsMid   = 2'sd0;
  localparam logic signed [ClassW-1:0] ClsLong  = 2'sd1;

  // Input kind carried on tuser
  localparam logic ActWidth = 1'b0;
  localparam logic ActTick  = 1'b1;

endpackage

/* design/atps_classify.sv */
module atps_classify import atps_pkg::*; (
  input  logic [WidthW-1:0]        min_i,
  input  logic [WidthW-1:0]        max_i,
  input  logic [WidthW-1:0]        cur_i,
  output logic signed [ClassW-1:0] cls_o
);

  logic signed [WidthW:0]   span;
  logic signed [WidthW:0]   half;
  logic [WidthW-1:0]        center;
  logic signed [WidthW+1:0] d_top;
  logic signed [WidthW+1:0] d_up;
  logic signed [WidthW+1:0] d_bot;
  logic signed [WidthW+1:0] d_down;

  always_comb begin
    span = $signed({1'b0, max_i}) - $signed({1'b0, min_i});
    // halve toward zero: bias negative spans by one before the shift
    half = (span + $signed({{WidthW{1'b0}}, span[WidthW]})) >>> 1;
    center = min_i + half[WidthW-1:0];

    d_top  = $signed({2'b00, max_i})  - $signed({2'b00, cur_i});
    d_up   = $signed({2'b00, cur_i})  - $signed({2'b00, center});
    d_bot  = $signed({2'b00, cur_i})  - $signed({2'b00, min_i});
    d_down = $signed({2'b00, center}) - $signed({2'b00, cur_i});

    if (cur_i > center) begin
      cls_o = (d_top < d_up) ? ClsLong : ClsMid;
    end else begin
      cls_o = (d_bot < d_down) ? ClsShort : ClsMid;
    end
  end

endmodule

/* design/autocal_tristate_pulse_slicer_unit.sv */
// Channel | Dir | Payload                                        | Handshake
// s_axis  | in  | tuser: action, tdata: width                    | tvalid/tready
// m_axis  | out | tdata: level_class, changed, fired, cleared    | tvalid/tready
// cfg     | in  | timeout_ticks                                  | valid/ready
//
// One transaction per cycle while m_axis accepts; inputs and results are registered.
// The rate is set by the calibration update in the compute stage.
// Reset clears all valid flags and loads the calibration and timeout defaults.
// A stalled m_axis holds the result; s_axis keeps accepting until both stages fill.
module autocal_tristate_pulse_slicer_unit import atps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [WidthW-1:0]   s_axis_tdata,  // [7:0] width
  input  logic                s_axis_tuser,  // [0] action
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // [1:0] level_class, [2] class_changed,
                                             // [3] timeout_fired, [4] calibration_cleared
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [TimeoutW-1:0] cfg_data_i
);

  logic                     in_valid_q, in_valid_d;
  logic                     in_action_q;
  logic [WidthW-1:0]        in_width_q;
  logic                     out_valid_q, out_valid_d;
  logic [OutDataW-1:0]      out_data_q;
  logic [TimeoutW-1:0]      timeout_q;

  logic [WidthW-1:0]        min_q, min_d;
  logic [WidthW-1:0]        max_q, max_d;
  logic [WidthW-1:0]        cur_q, cur_d;
  logic signed [ClassW-1:0] prev_q;
  logic [TimeoutW-1:0]      idle_q, idle_d;

  logic                     advance;
  logic                     process;
  logic [TimeoutW:0]        idle_inc;
  logic                     fired;
  logic                     cleared;
  logic                     changed;
  logic signed [ClassW-1:0] cls;
  logic [OutDataW-1:0]      out_data_d;

  assign advance       = !out_valid_q || m_axis_tready;
  assign process       = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    idle_inc = {1'b0, idle_q} + {{TimeoutW{1'b0}}, 1'b1};
    fired    = (in_action_q == ActTick) && (idle_inc >= {1'b0, timeout_q});
    cleared  = fired && (prev_q != ClsMid);

    min_d  = min_q;
    max_d  = max_q;
    cur_d  = cur_q;
    idle_d = idle_q;
    if (in_action_q == ActWidth) begin
      if (in_width_q < min_q) min_d = in_width_q;
      if (in_width_q > max_q) max_d = in_width_q;
      cur_d = in_width_q;
    end else if (fired) begin
      idle_d = '0;
      if (cleared) begin
        min_d = CalMinReset;
        max_d = CalMaxReset;
        cur_d = CalCurReset;
      end
    end else begin
      // below the timeout, so the count fits
      idle_d = idle_inc[TimeoutW-1:0];
    end
  end

  atps_classify u_classify (
    .min_i (min_d),
    .max_i (max_d),
    .cur_i (cur_d),
    .cls_o (cls)
  );

  assign changed    = (cls != prev_q);
  assign out_data_d = {3'b000, cleared, fired, changed, cls};

  assign in_valid_d  = s_axis_tready ? s_axis_tvalid : in_valid_q;
  assign out_valid_d = advance ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      timeout_q   <= TimeoutReset;
      min_q       <= CalMinReset;
      max_q       <= CalMaxReset;
      cur_q       <= CalCurReset;
      prev_q      <= ClsMid;
      idle_q      <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        timeout_q <= cfg_data_i;
      end
      if (process) begin
        min_q  <= min_d;
        max_q  <= max_d;
        cur_q  <= cur_d;
        prev_q <= cls;
        // restart the idle count on any class change
        idle_q <= changed ? '0 : idle_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_action_q <= s_axis_tuser;
      in_width_q  <= s_axis_tdata;
    end
    if (process) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

/* design/atps_checker.sv */
`include "assert_macros.svh"

module atps_checker import atps_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // the unused two-bit code never leaves the block
  `ASSERT_CLK(a_class_code, m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'b10), "bad class code")

  // calibration only clears as part of a timeout
  `ASSERT_CLK(a_clear_needs_fire, (m_axis_tvalid && m_axis_tdata[4]) |-> m_axis_tdata[3], "clear without timeout")

  // hold a stalled result
  `ASSERT_CLK(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

  // no result in the cycle after reset was seen
  `ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid, "result right after reset")

endmodule

bind autocal_tristate_pulse_slicer_unit atps_checker u_atps_checker (.*);
